### design/source_token_lexer_macros.svh
// assertion macros for the source token lexer checker
// expects clk and rst_n in the scope of each use
`ifndef SOURCE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_TOKEN_LEXER_MACROS_SVH

// same-cycle implication, disabled in reset
`define STL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, disabled in reset
`define STL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

### design/stl_pkg.sv
// shared types, constants and character helpers of the source token lexer
// no dependencies
package stl_pkg;

    localparam int POS_BITS      = 24;
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_IDX_W      = $clog2(KEYWORD_CHARS);
    localparam int WORD_BITS     = 8 * KEYWORD_CHARS;
    localparam int NUM_KW        = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [5:0]          kind_t;
    typedef logic [2:0]          err_t;

    localparam kind_t K_EOF     = 6'd0;
    localparam kind_t K_IDENT   = 6'd1;
    localparam kind_t K_INT     = 6'd2;
    localparam kind_t K_FLOAT   = 6'd3;
    localparam kind_t K_CHARLIT = 6'd4;
    localparam kind_t K_STRLIT  = 6'd5;
    localparam kind_t K_KW_BASE = 6'd6;
    localparam kind_t K_PLUS    = 6'd14;
    localparam kind_t K_STAR    = 6'd17;
    localparam kind_t K_SLASH   = 6'd18;
    localparam kind_t K_LPAREN  = 6'd27;
    localparam kind_t K_RPAREN  = 6'd28;
    localparam kind_t K_LBRACE  = 6'd29;
    localparam kind_t K_RBRACE  = 6'd30;
    localparam kind_t K_LBRACK  = 6'd31;
    localparam kind_t K_RBRACK  = 6'd32;
    localparam kind_t K_COMMA   = 6'd33;
    localparam kind_t K_SEMI    = 6'd34;
    localparam kind_t K_COLON   = 6'd35;
    localparam kind_t K_DOT     = 6'd36;
    localparam kind_t K_PERCENT = 6'd37;
    localparam kind_t K_CARET   = 6'd38;
    localparam kind_t K_TILDE   = 6'd39;
    localparam kind_t K_ERROR   = 6'd44;

    localparam err_t E_NONE       = 3'd0;
    localparam err_t E_OPEN_CMT   = 3'd1;
    localparam err_t E_OPEN_CHAR  = 3'd2;
    localparam err_t E_CHAR_LONG  = 3'd3;
    localparam err_t E_OPEN_STR   = 3'd4;
    localparam err_t E_BAD_CHAR   = 3'd5;

    // keywords, first character in the low byte, zero padded
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h6e66, 64'h726176, 64'h6e7275746572, 64'h646e65,
        64'h72616863, 64'h746e69, 64'h74616f6c66, 64'h676e69727473
    };

    typedef struct packed {
        kind_t       kind;
        err_t        err_code;
        logic [23:0] tok_offset;
        logic [23:0] tok_length;
        logic [23:0] tok_line;
        logic [23:0] tok_column;
    } res_t;

    typedef struct packed {
        logic [1:0]      cnt;
        res_t [2:0]      res;
    } bundle_t;

    typedef struct packed {
        logic       hit;
        kind_t      single;
        kind_t      dbl;
        logic [7:0] second;
    } pair_t;

    function automatic logic [23:0] to_out(pos_t v);
        logic [POS_BITS+23:0] t;
        t = {24'd0, v};
        return t[23:0];
    endfunction

    function automatic pos_t sat_inc(pos_t v);
        return (v == '1) ? v : v + pos_t'(1);
    endfunction

    function automatic pos_t sat_add(pos_t a, pos_t b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_BITS] ? '1 : s[POS_BITS-1:0];
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function automatic pair_t pair_lookup(logic [7:0] c);
        pair_t p;
        p = '0;
        unique case (c)
            8'h2d:   p = '{1'b1, 6'd15, 6'd16, 8'h3e};
            8'h3d:   p = '{1'b1, 6'd19, 6'd20, 8'h3d};
            8'h21:   p = '{1'b1, 6'd21, 6'd22, 8'h3d};
            8'h3c:   p = '{1'b1, 6'd23, 6'd24, 8'h3d};
            8'h3e:   p = '{1'b1, 6'd25, 6'd26, 8'h3d};
            8'h7c:   p = '{1'b1, 6'd40, 6'd41, 8'h7c};
            8'h26:   p = '{1'b1, 6'd42, 6'd43, 8'h26};
            default: p = '0;
        endcase
        return p;
    endfunction

    // zero when the byte is no single-character operator
    function automatic kind_t single_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            8'h2b:   k = K_PLUS;
            8'h2a:   k = K_STAR;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7b:   k = K_LBRACE;
            8'h7d:   k = K_RBRACE;
            8'h5b:   k = K_LBRACK;
            8'h5d:   k = K_RBRACK;
            8'h2c:   k = K_COMMA;
            8'h3b:   k = K_SEMI;
            8'h3a:   k = K_COLON;
            8'h2e:   k = K_DOT;
            8'h25:   k = K_PERCENT;
            8'h5e:   k = K_CARET;
            8'h7e:   k = K_TILDE;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

### design/stl_if.sv
// valid/ready channel interfaces of the source token lexer
// depends on stl_pkg
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, src_byte, end_of_source, input ready);
    modport sink   (input valid, src_byte, end_of_source, output ready);
endinterface

interface stl_out_if;
    logic               valid;
    logic               ready;
    stl_pkg::kind_t     kind;
    stl_pkg::err_t      err_code;
    logic [23:0]        tok_offset;
    logic [23:0]        tok_length;
    logic [23:0]        tok_line;
    logic [23:0]        tok_column;
    logic               last_of_run;

    modport source (output valid, kind, err_code, tok_offset, tok_length, tok_line,
                    tok_column, last_of_run, input ready);
    modport sink   (input valid, kind, err_code, tok_offset, tok_length, tok_line,
                    tok_column, last_of_run, output ready);
endinterface

### design/stl_front.sv
// scanner front end: one byte per transaction, builds a bundle of up to three results
// depends on stl_pkg
module stl_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        src_byte,
    input  logic              end_of_source,
    output logic              push,
    output stl_pkg::bundle_t  bundle
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_CHAR_OPEN, M_CHAR_GOT,
        M_CHAR_RECOVER, M_STRING, M_OP_PEND, M_SLASH_PEND, M_LINE_COMMENT,
        M_BLOCK_COMMENT, M_BLOCK_STAR
    } mode_t;

    mode_t                           mode_reg, mode_next;
    stl_pkg::pos_t                   pos_reg, pos_next;
    stl_pkg::pos_t                   line_reg, line_next;
    stl_pkg::pos_t                   col_reg, col_next;
    stl_pkg::pos_t                   soff_reg, soff_next;
    stl_pkg::pos_t                   sline_reg, sline_next;
    stl_pkg::pos_t                   scol_reg, scol_next;
    stl_pkg::pos_t                   run_reg, run_next;
    logic [stl_pkg::WORD_BITS-1:0]   word_reg, word_next;
    logic                            wlong_reg, wlong_next;
    logic [7:0]                      pend_reg, pend_next;

    logic             ea, eb, ec;
    stl_pkg::kind_t   ka, kc, kw;
    stl_pkg::err_t    ca, cc;
    stl_pkg::pos_t    la, lc, il;
    stl_pkg::res_t    ra, rb, rc;
    stl_pkg::pair_t   pp, pc;
    logic             do_idle;

    function automatic stl_pkg::kind_t word_kind(logic [stl_pkg::WORD_BITS-1:0] w,
                                                  logic too_long);
        stl_pkg::kind_t k;
        k = stl_pkg::K_IDENT;
        if (!too_long)
        begin
            for (int i = 0; i < stl_pkg::NUM_KW; i++)
            begin
                if (w == stl_pkg::KW_TEXT[i][stl_pkg::WORD_BITS-1:0])
                begin
                    k = stl_pkg::K_KW_BASE + stl_pkg::kind_t'(i);
                end
            end
        end
        return k;
    endfunction

    assign kw = word_kind(word_reg, wlong_reg);
    assign pp = stl_pkg::pair_lookup(pend_reg);
    assign pc = stl_pkg::pair_lookup(src_byte);
    assign il = run_reg - stl_pkg::pos_t'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        soff_next  = soff_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        run_next   = run_reg;
        word_next  = word_reg;
        wlong_next = wlong_reg;
        pend_next  = pend_reg;
        ea = 1'b0; eb = 1'b0; ec = 1'b0;
        ka = stl_pkg::K_EOF; ca = stl_pkg::E_NONE; la = '0;
        kc = stl_pkg::K_EOF; cc = stl_pkg::E_NONE; lc = '0;
        do_idle = 1'b0;

        if (end_of_source)
        begin
            unique case (mode_reg)
                M_IDENT:      begin ea = 1'b1; ka = kw; la = run_reg; end
                M_NUM_INT:    begin ea = 1'b1; ka = stl_pkg::K_INT; la = run_reg; end
                M_NUM_DOT:    begin ea = 1'b1; eb = 1'b1; ka = stl_pkg::K_INT; la = il; end
                M_NUM_FRAC:   begin ea = 1'b1; ka = stl_pkg::K_FLOAT; la = run_reg; end
                M_CHAR_OPEN:
                begin
                    ea = 1'b1; ka = stl_pkg::K_ERROR; ca = stl_pkg::E_OPEN_CHAR; la = run_reg;
                end
                M_CHAR_GOT:
                begin
                    ea = 1'b1; ka = stl_pkg::K_ERROR; ca = stl_pkg::E_CHAR_LONG; la = run_reg;
                end
                M_STRING:
                begin
                    ea = 1'b1; ka = stl_pkg::K_ERROR; ca = stl_pkg::E_OPEN_STR; la = run_reg;
                end
                M_OP_PEND:    begin ea = 1'b1; ka = pp.single; la = stl_pkg::pos_t'(1); end
                M_SLASH_PEND: begin ea = 1'b1; ka = stl_pkg::K_SLASH; la = stl_pkg::pos_t'(1); end
                M_BLOCK_COMMENT, M_BLOCK_STAR:
                begin
                    ea = 1'b1; ka = stl_pkg::K_ERROR; ca = stl_pkg::E_OPEN_CMT; la = run_reg;
                end
                default: ;
            endcase
            ec = 1'b1;
            kc = stl_pkg::K_EOF;
            lc = '0;
            mode_next = M_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (stl_pkg::is_alpha(src_byte) || stl_pkg::is_digit(src_byte))
                    begin
                        if (run_reg < stl_pkg::pos_t'(stl_pkg::KEYWORD_CHARS))
                            word_next[8*run_reg[stl_pkg::KW_IDX_W-1:0] +: 8] = src_byte;
                        else
                            wlong_next = 1'b1;
                    end
                    else
                    begin
                        ea = 1'b1; ka = kw; la = run_reg; do_idle = 1'b1;
                    end
                end
                M_NUM_INT:
                begin
                    if (src_byte == 8'h2e)
                        mode_next = M_NUM_DOT;
                    else if (!stl_pkg::is_digit(src_byte))
                    begin
                        ea = 1'b1; ka = stl_pkg::K_INT; la = run_reg; do_idle = 1'b1;
                    end
                end
                M_NUM_DOT:
                begin
                    if (stl_pkg::is_digit(src_byte))
                        mode_next = M_NUM_FRAC;
                    else
                    begin
                        ea = 1'b1; eb = 1'b1; ka = stl_pkg::K_INT; la = il; do_idle = 1'b1;
                    end
                end
                M_NUM_FRAC:
                begin
                    if (!stl_pkg::is_digit(src_byte))
                    begin
                        ea = 1'b1; ka = stl_pkg::K_FLOAT; la = run_reg; do_idle = 1'b1;
                    end
                end
                M_CHAR_OPEN: mode_next = M_CHAR_GOT;
                M_CHAR_GOT:
                begin
                    ea = 1'b1;
                    if (src_byte == 8'h27)
                    begin
                        ka = stl_pkg::K_CHARLIT; la = stl_pkg::sat_inc(run_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        ka = stl_pkg::K_ERROR; ca = stl_pkg::E_CHAR_LONG; la = run_reg;
                        mode_next = (src_byte == 8'h0a) ? M_IDLE : M_CHAR_RECOVER;
                    end
                end
                M_CHAR_RECOVER:
                    if (src_byte == 8'h27 || src_byte == 8'h0a) mode_next = M_IDLE;
                M_STRING:
                begin
                    if (src_byte == 8'h22 || src_byte == 8'h0a)
                    begin
                        ea = 1'b1; ka = stl_pkg::K_STRLIT; la = stl_pkg::sat_inc(run_reg);
                        mode_next = M_IDLE;
                    end
                end
                M_OP_PEND:
                begin
                    ea = 1'b1;
                    if (pp.hit && pp.second == src_byte)
                    begin
                        ka = pp.dbl; la = stl_pkg::pos_t'(2); mode_next = M_IDLE;
                    end
                    else
                    begin
                        ka = pp.single; la = stl_pkg::pos_t'(1); do_idle = 1'b1;
                    end
                end
                M_SLASH_PEND:
                begin
                    if (src_byte == 8'h2f)
                        mode_next = M_LINE_COMMENT;
                    else if (src_byte == 8'h2a)
                        mode_next = M_BLOCK_COMMENT;
                    else
                    begin
                        ea = 1'b1; ka = stl_pkg::K_SLASH; la = stl_pkg::pos_t'(1);
                        do_idle = 1'b1;
                    end
                end
                M_LINE_COMMENT:
                    if (src_byte == 8'h0a) mode_next = M_IDLE;
                M_BLOCK_COMMENT:
                    if (src_byte == 8'h2a) mode_next = M_BLOCK_STAR;
                M_BLOCK_STAR:
                begin
                    if (src_byte == 8'h2f)
                        mode_next = M_IDLE;
                    else if (src_byte != 8'h2a)
                        mode_next = M_BLOCK_COMMENT;
                end
                default: do_idle = 1'b1;
            endcase

            // byte seen between tokens
            if (do_idle)
            begin
                mode_next = M_IDLE;
                if (!stl_pkg::is_ws(src_byte))
                begin
                    if (stl_pkg::is_alpha(src_byte) || stl_pkg::is_digit(src_byte) ||
                        src_byte == 8'h27 || src_byte == 8'h22 || src_byte == 8'h2f ||
                        pc.hit)
                    begin
                        soff_next  = pos_reg;
                        sline_next = line_reg;
                        scol_next  = col_reg;
                        run_next   = '0;
                        if (stl_pkg::is_alpha(src_byte))
                        begin
                            mode_next  = M_IDENT;
                            word_next  = '0;
                            word_next[7:0] = src_byte;
                            wlong_next = 1'b0;
                        end
                        else if (stl_pkg::is_digit(src_byte))
                            mode_next = M_NUM_INT;
                        else if (src_byte == 8'h27)
                            mode_next = M_CHAR_OPEN;
                        else if (src_byte == 8'h22)
                            mode_next = M_STRING;
                        else if (src_byte == 8'h2f)
                            mode_next = M_SLASH_PEND;
                        else
                        begin
                            mode_next = M_OP_PEND;
                            pend_next = src_byte;
                        end
                    end
                    else
                    begin
                        ec = 1'b1;
                        lc = stl_pkg::pos_t'(1);
                        kc = stl_pkg::single_kind(src_byte);
                        if (kc == stl_pkg::K_EOF)
                        begin
                            kc = stl_pkg::K_ERROR;
                            cc = stl_pkg::E_BAD_CHAR;
                        end
                    end
                end
            end

            if (mode_next != M_IDLE) run_next = stl_pkg::sat_inc(run_next);
            pos_next = pos_reg + stl_pkg::pos_t'(1);
            if (src_byte == 8'h0a)
            begin
                line_next = stl_pkg::sat_inc(line_reg);
                col_next  = stl_pkg::pos_t'(1);
            end
            else
                col_next = stl_pkg::sat_inc(col_reg);
        end
    end

    always_comb
    begin
        ra = '{ka, ca, stl_pkg::to_out(soff_reg), stl_pkg::to_out(la),
               stl_pkg::to_out(sline_reg), stl_pkg::to_out(scol_reg)};
        rb = '{stl_pkg::K_DOT, stl_pkg::E_NONE, stl_pkg::to_out(soff_reg + il), 24'd1,
               stl_pkg::to_out(sline_reg), stl_pkg::to_out(stl_pkg::sat_add(scol_reg, il))};
        rc = '{kc, cc, stl_pkg::to_out(pos_reg), stl_pkg::to_out(lc),
               stl_pkg::to_out(line_reg), stl_pkg::to_out(col_reg)};
        // possible sets are a, c, a+c, a+b, a+b+c
        bundle.res[0] = ea ? ra : rc;
        bundle.res[1] = eb ? rb : rc;
        bundle.res[2] = rc;
        bundle.cnt    = 2'({1'b0, ea} + {1'b0, eb} + {1'b0, ec});
    end

    assign push = step && (ea || eb || ec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            line_reg  <= stl_pkg::pos_t'(1);
            col_reg   <= stl_pkg::pos_t'(1);
            soff_reg  <= '0;
            sline_reg <= stl_pkg::pos_t'(1);
            scol_reg  <= stl_pkg::pos_t'(1);
            run_reg   <= '0;
            word_reg  <= '0;
            wlong_reg <= 1'b0;
            pend_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            soff_reg  <= soff_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            run_reg   <= run_next;
            word_reg  <= word_next;
            wlong_reg <= wlong_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### design/stl_queue.sv
// small bundle queue between scanner front end and result drain
// depends on stl_pkg
module stl_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stl_pkg::bundle_t  push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output stl_pkg::bundle_t  head
);

    stl_pkg::bundle_t            mem_reg [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::QPTR_W-1:0]  wr_reg, rd_reg;
    logic [stl_pkg::QPTR_W:0]    cnt_reg;

    assign full      = (cnt_reg == (stl_pkg::QPTR_W+1)'(stl_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + stl_pkg::QPTR_W'(1);
            if (pop)  rd_reg <= rd_reg + stl_pkg::QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (stl_pkg::QPTR_W+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (stl_pkg::QPTR_W+1)'(1);
        end
    end

endmodule

### design/stl_drain.sv
// result drain: sends the results of the head bundle one per transaction
// depends on stl_pkg
module stl_drain
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              have,
    input  stl_pkg::bundle_t  head,
    input  logic              taken,
    output logic              pop,
    output logic              valid,
    output stl_pkg::res_t     res,
    output logic              last
);

    logic [1:0] idx_reg;

    assign valid = have;
    assign res   = head.res[idx_reg];
    assign last  = (idx_reg == head.cnt - 2'd1);
    assign pop   = taken && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (taken)
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
    end

endmodule

### design/source_token_lexer.sv
// top level of the source token lexer: front end, bundle queue, result drain
// depends on stl_pkg, stl_if, stl_front, stl_queue, stl_drain
//
// in_ch carries one source byte per transaction, or an end mark
// (end_of_source) that flushes the pending token and adds an eof token.
// out_ch carries one token or error item per transaction; last_of_run marks
// the final result caused by one input transaction (one to three results).
// A byte that causes no result (whitespace, comment body, growing token)
// produces nothing on out_ch.
// Throughput: one input transaction per cycle while the queue has room; the
// output side sends one result per cycle while out_ch.ready is high, so inputs
// producing several results are limited by the drain. The front end writes an
// input's result bundle into the four-entry queue, whose head drives out_ch
// directly from the registered queue entry.
// Reset clears the scan state to idle between tokens, offset 0, line 1,
// column 1, and empties the queue.
// When the receiver stalls, the queue absorbs up to four bundles; once it is
// full in_ch.ready drops until a bundle has been fully delivered.
module source_token_lexer
(
    input  logic       clk,
    input  logic       rst_n,
    stl_in_if.sink     in_ch,
    stl_out_if.source  out_ch
);

    logic              step;
    logic              push;
    logic              full;
    logic              have;
    logic              pop;
    logic              taken;
    stl_pkg::bundle_t  bundle;
    stl_pkg::bundle_t  head;
    stl_pkg::res_t     res;

    // the front end only advances when its bundle has a place to go
    assign in_ch.ready = !full;
    assign step        = in_ch.valid && !full;
    assign taken       = out_ch.valid && out_ch.ready;

    stl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .src_byte      (in_ch.src_byte),
        .end_of_source (in_ch.end_of_source),
        .push          (push),
        .bundle        (bundle)
    );

    stl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .pop       (pop),
        .full      (full),
        .not_empty (have),
        .head      (head)
    );

    stl_drain u_drain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .have  (have),
        .head  (head),
        .taken (taken),
        .pop   (pop),
        .valid (out_ch.valid),
        .res   (res),
        .last  (out_ch.last_of_run)
    );

    // result fields out of the head bundle
    assign out_ch.kind       = res.kind;
    assign out_ch.err_code   = res.err_code;
    assign out_ch.tok_offset = res.tok_offset;
    assign out_ch.tok_length = res.tok_length;
    assign out_ch.tok_line   = res.tok_line;
    assign out_ch.tok_column = res.tok_column;

endmodule

### design/stl_checker.sv
// port-level checks of the source token lexer, bound to the top level
// depends on stl_pkg and source_token_lexer_macros.svh
`include "source_token_lexer_macros.svh"

module stl_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            out_valid,
    input  logic            out_ready,
    input  stl_pkg::kind_t  kind,
    input  stl_pkg::err_t   err_code,
    input  logic [23:0]     tok_length,
    input  logic            last_of_run
);

    `STL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind))
    `STL_ASSERT_NOW(a_code_on_token, out_valid && kind != stl_pkg::K_ERROR, err_code == stl_pkg::E_NONE)
    `STL_ASSERT_NOW(a_code_on_error, out_valid && kind == stl_pkg::K_ERROR, err_code != stl_pkg::E_NONE)
    `STL_ASSERT_NOW(a_eof_closes, out_valid && kind == stl_pkg::K_EOF, last_of_run && tok_length == 24'd0)

endmodule

bind source_token_lexer stl_checker u_stl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .kind        (out_ch.kind),
    .err_code    (out_ch.err_code),
    .tok_length  (out_ch.tok_length),
    .last_of_run (out_ch.last_of_run)
);
